// ===== design/pcm_sample_to_float32_macros.svh =====
// Assertion macros used by the checker file of the PCM to float32 converter.
`ifndef PCM_SAMPLE_TO_FLOAT32_MACROS_SVH
`define PCM_SAMPLE_TO_FLOAT32_MACROS_SVH

// Clocked property that is ignored while reset is asserted.
`define PCM2F_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked property that is also checked while reset is asserted.
`define PCM2F_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/pcm2f_pkg.sv =====
// Formats, widths and reciprocal constants for the PCM to float32 converter.
package pcm2f_pkg;

	localparam int FMT_W    = 3;
	localparam int SAMPLE_W = 32;
	localparam int RECIP_W  = 43;

	localparam logic [FMT_W-1:0] FMT_S8  = 3'd0;
	localparam logic [FMT_W-1:0] FMT_U8  = 3'd1;
	localparam logic [FMT_W-1:0] FMT_S16 = 3'd2;
	localparam logic [FMT_W-1:0] FMT_U16 = 3'd3;
	localparam logic [FMT_W-1:0] FMT_S32 = 3'd4;
	localparam logic [FMT_W-1:0] FMT_U32 = 3'd5;
	localparam logic [FMT_W-1:0] FMT_F32 = 3'd6;
	localparam logic [FMT_W-1:0] FMT_UNUSED = 3'd7;
	localparam logic [FMT_W-1:0] FMT_RESET = FMT_S16;

	// Rounded-up reciprocals of 2^k-1, scaled by 2^(42+k).
	localparam logic [RECIP_W-1:0] RECIP_K7 = (43'd1 << 42) + (43'd1 << 35) + (43'd1 << 28)
		+ (43'd1 << 21) + (43'd1 << 14) + (43'd1 << 7) + 43'd2;
	localparam logic [RECIP_W-1:0] RECIP_K8 = (43'd1 << 42) + (43'd1 << 34) + (43'd1 << 26)
		+ (43'd1 << 18) + (43'd1 << 10) + (43'd1 << 2) + 43'd1;
	localparam logic [RECIP_W-1:0] RECIP_K15 = (43'd1 << 42) + (43'd1 << 27) + (43'd1 << 12)
		+ 43'd1;
	localparam logic [RECIP_W-1:0] RECIP_K16 = (43'd1 << 42) + (43'd1 << 26) + (43'd1 << 10)
		+ 43'd1;

	function automatic logic [RECIP_W-1:0] recip(input logic [FMT_W-1:0] fmt);
		logic [RECIP_W-1:0] r;
		unique case (fmt)
			FMT_S8:  r = RECIP_K7;
			FMT_U8:  r = RECIP_K8;
			FMT_S16: r = RECIP_K15;
			FMT_U16: r = RECIP_K16;
			default: r = '0;
		endcase
		return r;
	endfunction

	// Exponent base 127-k for the narrow formats.
	function automatic logic [7:0] narrow_exp_base(input logic [FMT_W-1:0] fmt);
		logic [7:0] e;
		unique case (fmt)
			FMT_S8:  e = 8'd120;
			FMT_U8:  e = 8'd119;
			FMT_S16: e = 8'd112;
			default: e = 8'd111;
		endcase
		return e;
	endfunction

endpackage

// ===== design/pcm_sample_to_float32.sv =====
// Top level of the PCM sample to float32 converter.
// Converts one PCM sample per request into an IEEE single precision value.
// The slave channel carries the raw sample in tdata and the frame-end mark in
// tlast; the master channel returns the float pattern in tdata and the copied
// mark in tlast. cfg_wr_en with cfg_wr_data selects the sample format:
// 0 s8, 1 u8, 2 s16, 3 u16, 4 s32, 5 u32, 6 f32 passthrough; write it only
// while no request is in flight.
// A request can be accepted in every cycle while the receiver keeps up, so
// throughput is one sample per cycle. Each result passes the five register
// stages (magnitude, normalise, split reciprocal product, product sum, round
// and pack) before it shows on the master side.
// Narrow formats divide by 2^k-1 through a multiply by a scaled reciprocal;
// the 32 bit formats only need a rounded normalise and an exponent offset.
// Reset empties the pipeline and sets the format to s16.
// When the receiver stalls, each stage holds until the one after it frees,
// so tready falls only once the pipeline is full; nothing is lost or repeated.
module pcm_sample_to_float32 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_wr_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] sample_bits
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] float_bits
	output logic        m_axis_tlast
);

	logic [pcm2f_pkg::FMT_W-1:0] fmt_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= pcm2f_pkg::FMT_RESET;
		end else if (cfg_wr_en) begin
			fmt_q <= cfg_wr_data;
		end
	end

	assign rdy5 = !v_s5 || m_axis_tready;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign s_axis_tready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= s_axis_tvalid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// Stage 1: extend the sample, take its magnitude and settle the bypass cases.
	logic [31:0] sx, mag;
	logic        neg, byp;
	logic [31:0] byp_bits;

	always_comb begin
		sx = s_axis_tdata;
		case (fmt_q)
			pcm2f_pkg::FMT_S8:  sx = {{24{s_axis_tdata[7]}}, s_axis_tdata[7:0]};
			pcm2f_pkg::FMT_U8:  sx = {24'd0, s_axis_tdata[7:0]};
			pcm2f_pkg::FMT_S16: sx = {{16{s_axis_tdata[15]}}, s_axis_tdata[15:0]};
			pcm2f_pkg::FMT_U16: sx = {16'd0, s_axis_tdata[15:0]};
			default:            sx = s_axis_tdata;
		endcase
		neg = sx[31] && (fmt_q == pcm2f_pkg::FMT_S8 || fmt_q == pcm2f_pkg::FMT_S16
			|| fmt_q == pcm2f_pkg::FMT_S32);
		mag = neg ? (~sx + 32'd1) : sx;
		byp = (fmt_q == pcm2f_pkg::FMT_F32) || (fmt_q > pcm2f_pkg::FMT_F32) || (mag == 32'd0);
		byp_bits = 32'd0;
		if (fmt_q == pcm2f_pkg::FMT_F32) begin
			// A signalling NaN comes out quiet.
			if (s_axis_tdata[30:23] == 8'hFF && s_axis_tdata[22:0] != 23'd0)
				byp_bits = s_axis_tdata | 32'h0040_0000;
			else
				byp_bits = s_axis_tdata;
		end
	end

	logic [31:0]                 mag_s1, byp_bits_s1;
	logic                        neg_s1, byp_s1, last_s1;
	logic [pcm2f_pkg::FMT_W-1:0] fmt_s1;

	always_ff @(posedge clk) begin
		if (rdy1) begin
			mag_s1      <= mag;
			neg_s1      <= neg;
			byp_s1      <= byp;
			byp_bits_s1 <= byp_bits;
			last_s1     <= s_axis_tlast;
			fmt_s1      <= fmt_q;
		end
	end

	// Stage 2: find the leading one and normalise to bit 31.
	logic [4:0]  msb;
	logic [31:0] norm;

	always_comb begin
		msb = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (mag_s1[i]) msb = 5'(i);
		end
		norm = mag_s1 << (5'd31 - msb);
	end

	logic [31:0]                 norm_s2, byp_bits_s2;
	logic [4:0]                  msb_s2;
	logic                        neg_s2, byp_s2, last_s2;
	logic [pcm2f_pkg::FMT_W-1:0] fmt_s2;

	always_ff @(posedge clk) begin
		if (rdy2) begin
			norm_s2     <= norm;
			msb_s2      <= msb;
			neg_s2      <= neg_s1;
			byp_s2      <= byp_s1;
			byp_bits_s2 <= byp_bits_s1;
			last_s2     <= last_s1;
			fmt_s2      <= fmt_s1;
		end
	end

	// Stage 3: reciprocal product in two halves, and the wide-format rounding inputs.
	logic [pcm2f_pkg::RECIP_W-1:0] rc;
	logic                          narrow;
	logic [7:0]                    exp_base;

	always_comb begin
		rc = pcm2f_pkg::recip(fmt_s2);
		narrow = (fmt_s2 == pcm2f_pkg::FMT_S8) || (fmt_s2 == pcm2f_pkg::FMT_U8)
			|| (fmt_s2 == pcm2f_pkg::FMT_S16) || (fmt_s2 == pcm2f_pkg::FMT_U16);
		if (narrow)
			exp_base = pcm2f_pkg::narrow_exp_base(fmt_s2) + {3'd0, msb_s2};
		else if (fmt_s2 == pcm2f_pkg::FMT_S32)
			exp_base = 8'd96 + {3'd0, msb_s2};
		else
			exp_base = 8'd95 + {3'd0, msb_s2};
	end

	logic [37:0] pl_s3;
	logic [36:0] ph_s3;
	logic [23:0] wmant_s3;
	logic        wrnd_s3, narrow_s3, neg_s3, byp_s3, last_s3;
	logic [7:0]  exp_s3;
	logic [31:0] byp_bits_s3;

	always_ff @(posedge clk) begin
		if (rdy3) begin
			pl_s3       <= 38'(norm_s2[31:16] * rc[21:0]);
			ph_s3       <= 37'(norm_s2[31:16] * rc[42:22]);
			wmant_s3    <= norm_s2[31:8];
			wrnd_s3     <= norm_s2[7] && ((|norm_s2[6:0]) || norm_s2[8]);
			narrow_s3   <= narrow;
			exp_s3      <= exp_base;
			neg_s3      <= neg_s2;
			byp_s3      <= byp_s2;
			byp_bits_s3 <= byp_bits_s2;
			last_s3     <= last_s2;
		end
	end

	// Stage 4: sum the partial products into the scaled quotient.
	logic [58:0] y_s4;
	logic [23:0] wmant_s4;
	logic        wrnd_s4, narrow_s4, neg_s4, byp_s4, last_s4;
	logic [7:0]  exp_s4;
	logic [31:0] byp_bits_s4;

	always_ff @(posedge clk) begin
		if (rdy4) begin
			y_s4        <= {ph_s3, 22'd0} + {21'd0, pl_s3};
			wmant_s4    <= wmant_s3;
			wrnd_s4     <= wrnd_s3;
			narrow_s4   <= narrow_s3;
			exp_s4      <= exp_s3;
			neg_s4      <= neg_s3;
			byp_s4      <= byp_s3;
			byp_bits_s4 <= byp_bits_s3;
			last_s4     <= last_s3;
		end
	end

	// Stage 5: round and pack. The quotient never lies on a tie unless it is
	// exact, so the narrow path rounds on its round bit alone.
	logic [23:0] mant;
	logic        rnd;
	logic [7:0]  exp_pre, exp_fin;
	logic [24:0] msum;
	logic [31:0] result;

	always_comb begin
		exp_pre = exp_s4;
		if (narrow_s4) begin
			if (y_s4[58]) begin
				mant = 24'h80_0000;
				rnd = 1'b0;
				exp_pre = exp_s4 + 8'd1;
			end else begin
				mant = y_s4[57:34];
				rnd = y_s4[33];
			end
		end else begin
			mant = wmant_s4;
			rnd = wrnd_s4;
		end
		msum = {1'b0, mant} + {24'd0, rnd};
		exp_fin = exp_pre + {7'd0, msum[24]};
		result = byp_s4 ? byp_bits_s4 : {neg_s4, exp_fin, msum[22:0]};
	end

	logic [31:0] result_s5;
	logic        last_s5;

	always_ff @(posedge clk) begin
		if (rdy5) begin
			result_s5 <= result;
			last_s5   <= last_s4;
		end
	end

	assign m_axis_tvalid = v_s5;
	assign m_axis_tdata  = result_s5;
	assign m_axis_tlast  = last_s5;

endmodule

// ===== design/pcm2f_chk.sv =====
// Port-level checker for the PCM to float32 converter, with its bind.
`include "pcm_sample_to_float32_macros.svh"

module pcm2f_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic        m_axis_tlast
);

	// A stalled result keeps its contents.
	`PCM2F_ASSERT(a_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")

	// With the receiver taking results, the pipeline never pushes back.
	`PCM2F_ASSERT(a_no_backpressure, m_axis_tready |-> s_axis_tready, "input stalled without output stall")

	// An accepted request surfaces at the output while the receiver keeps taking results.
	`PCM2F_ASSERT(a_latency, s_axis_tvalid && s_axis_tready && m_axis_tready ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready |=> m_axis_tvalid, "result missing after five cycles")

	// Reset has emptied the pipeline by the following clock edge.
	`PCM2F_ASSERT_RST(a_reset_empty, !arst_n |=> !m_axis_tvalid, "result shown during reset")

endmodule

bind pcm_sample_to_float32 pcm2f_chk u_pcm2f_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

// ===== test/tb.sv =====
// Self-checking testbench for the PCM sample to float32 converter, with a scoreboard class.
`timescale 1ns / 1ps

typedef struct packed {
	logic [31:0] float_bits;
	logic        frame_end;
} pcm_result_t;

class pcm_scoreboard;
	pcm_result_t pending_results[$];
	int          error_count;
	int          checked_count;

	// Rounds m * 2^e2 to single precision, nearest even; sticky marks a nonzero tail below m.
	function automatic logic [31:0] pack_single(bit neg, logic [63:0] m, int e2, bit sticky);
		int          p;
		int          sh;
		logic [63:0] kept;
		logic [63:0] rem;
		logic [63:0] half;
		logic [7:0]  exp_field;
		if (m == 0) begin
			return 32'd0;
		end
		p = 63;
		while (!m[p]) begin
			p--;
		end
		if (p > 23) begin
			sh = p - 23;
			kept = m >> sh;
			rem = m & ((64'd1 << sh) - 1);
			half = 64'd1 << (sh - 1);
			if (rem > half || (rem == half && (sticky || kept[0]))) begin
				kept++;
			end
			if (kept[24]) begin
				kept = kept >> 1;
				p++;
			end
		end else begin
			kept = m << (23 - p);
		end
		exp_field = 8'(p + e2 + 127);
		return {neg, exp_field, kept[22:0]};
	endfunction

	// Sample scaled by a narrow format's maximum 2^k-1.
	function automatic logic [31:0] scale_narrow(longint v, longint divisor);
		bit          neg;
		logic [63:0] mag;
		logic [63:0] num;
		neg = v < 0;
		mag = neg ? -v : v;
		num = mag << 40;
		return pack_single(neg, num / divisor, -40, (num % divisor) != 0);
	endfunction

	function automatic logic [31:0] normalise_sample(logic [2:0] fmt, logic [31:0] raw);
		longint v;
		bit     neg;
		case (fmt)
			pcm2f_pkg::FMT_S8:  return scale_narrow(longint'($signed(raw[7:0])), 127);
			pcm2f_pkg::FMT_U8:  return scale_narrow(longint'(raw[7:0]), 255);
			pcm2f_pkg::FMT_S16: return scale_narrow(longint'($signed(raw[15:0])), 32767);
			pcm2f_pkg::FMT_U16: return scale_narrow(longint'(raw[15:0]), 65535);
			pcm2f_pkg::FMT_S32: begin
				v = longint'($signed(raw));
				neg = v < 0;
				return pack_single(neg, neg ? 64'(-v) : 64'(v), -31, 1'b0);
			end
			pcm2f_pkg::FMT_U32: return pack_single(1'b0, 64'(raw), -32, 1'b0);
			pcm2f_pkg::FMT_F32: begin
				// A signalling NaN comes out quiet.
				if (raw[30:23] == 8'hFF && raw[22:0] != 0) begin
					return raw | 32'h0040_0000;
				end
				return raw;
			end
			default: return 32'd0;
		endcase
	endfunction

	function void note_request(logic [2:0] fmt, logic [31:0] raw, logic last);
		pending_results.push_back('{normalise_sample(fmt, raw), last});
	endfunction

	function void check_result(logic [31:0] bits, logic last);
		pcm_result_t exp_r;
		if (pending_results.size() == 0) begin
			$display("%0t: unexpected result %h last %b", $time, bits, last);
			error_count++;
			return;
		end
		exp_r = pending_results.pop_front();
		checked_count++;
		if (exp_r.float_bits !== bits) begin
			$display("%0t: float_bits expected %h actual %h", $time, exp_r.float_bits, bits);
			error_count++;
		end
		if (exp_r.frame_end !== last) begin
			$display("%0t: frame_end expected %b actual %b", $time, exp_r.frame_end, last);
			error_count++;
		end
	endfunction
endclass

module tb;
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [2:0]  cfg_wr_data = pcm2f_pkg::FMT_RESET;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tlast;

	pcm_scoreboard scoreboard = new();
	logic [2:0]    current_format = pcm2f_pkg::FMT_RESET;
	bit            no_idling = 1'b0;
	int            sink_stall = 0;
	int            formats_run = 0;

	pcm_sample_to_float32 DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),   // [31:0] sample_bits
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),   // [31:0] float_bits
		.m_axis_tlast(m_axis_tlast)
	);

	always #2 clk = ~clk;

	// Sink side: check every accepted result and, unless no_idling is set, stall in short random bursts.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				scoreboard.check_result(m_axis_tdata, m_axis_tlast);
			end
			if (sink_stall > 0) begin
				sink_stall <= sink_stall - 1;
				m_axis_tready <= 1'b0;
			end else if (!no_idling && $urandom_range(0, 5) == 0) begin
				sink_stall <= $urandom_range(0, 3);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Presents one request and holds it until it is accepted; tvalid may then drop for an idle gap.
	task automatic send_sample(logic [31:0] raw, logic last);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= raw;
		s_axis_tlast <= last;
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
		scoreboard.note_request(current_format, raw, last);
		if (!no_idling && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic drain_pipeline();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (scoreboard.pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic write_format(logic [2:0] fmt);
		drain_pipeline();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= fmt;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		current_format = fmt;
		formats_run++;
	endtask

	function automatic logic [31:0] random_sample();
		logic [31:0] r;
		r = $urandom();
		case ($urandom_range(0, 3))
			0: r = r & 32'h0000_00FF;
			1: r = r & 32'h0000_FFFF;
			2: r = r >> $urandom_range(0, 31);
			default: ;
		endcase
		return r;
	endfunction

	task automatic run_random(int count);
		repeat (count) begin
			send_sample(random_sample(), $urandom_range(0, 7) == 0);
		end
	endtask

	logic [31:0] edge_samples[12] = '{
		32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_007F, 32'h0000_0080,
		32'h0000_7FFF, 32'h0000_8000, 32'h7FFF_FFFF, 32'h8000_0000,
		32'h0000_0001, 32'hABCD_FF81, 32'h00FF_FFFF, 32'h0100_0001
	};
	logic [31:0] float_samples[12] = '{
		32'h7F80_0001, 32'hFFBF_FFFF, 32'h7FC0_0000, 32'h7F80_0000,
		32'hFF80_0000, 32'h8000_0000, 32'h0000_0001, 32'h3F80_0000,
		32'h807F_FFFF, 32'h7F7F_FFFF, 32'h7FA0_0000, 32'hC2F6_E979
	};
	logic [2:0] format_order[8] = '{pcm2f_pkg::FMT_S8, pcm2f_pkg::FMT_U8,
		pcm2f_pkg::FMT_U16, pcm2f_pkg::FMT_S32, pcm2f_pkg::FMT_U32,
		pcm2f_pkg::FMT_F32, pcm2f_pkg::FMT_UNUSED, pcm2f_pkg::FMT_S16};

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Edge values under the reset format, before any register write.
		foreach (edge_samples[i]) begin
			send_sample(edge_samples[i], i % 3 == 0);
		end
		run_random(60);
		foreach (format_order[k]) begin
			write_format(format_order[k]);
			if (format_order[k] == pcm2f_pkg::FMT_F32) begin
				foreach (float_samples[i]) begin
					send_sample(float_samples[i], i % 2 == 0);
				end
			end
			if (k == 7) begin
				no_idling = 1'b1;
			end
			run_random(65);
		end
		drain_pipeline();
		$display("Covered the reset format and %0d written formats, unused code included.",
			formats_run);
		$display("Checked %0d results against the predicted float patterns.",
			scoreboard.checked_count);
		if (scoreboard.error_count == 0 && scoreboard.pending_results.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Timed out with %0d results outstanding.", scoreboard.pending_results.size());
		$display("DONE: errors detected");
		$finish;
	end
endmodule
